[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/oaht_pkg.sv]
// types and constants of the open addressing hash table
`default_nettype none

package oaht_pkg;

	// width of the modulus register and of the home remainder
	localparam int MOD_W = 6;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	typedef enum logic {
		REG_MODULUS = 1'b0,
		REG_STEP    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] key;
		logic [15:0] score;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  slot;
		logic [15:0] found_score;
		logic [5:0]  probe_count;
	} rsp_t;

endpackage

`default_nettype wire

[src/open_addressing_hash_table.sv]
// top level of the open addressing hash table with fixed-step probing
`default_nettype none
`include "assert_macros.svh"

// usage
// - req channel (valid/ready) carries one command per transfer: clear, insert,
//   search or delete, with key and score; rsp channel returns one result
//   (status, slot, found score, probe count) per command, in order
// - apb port: 0x0 hash modulus, 0x4 probe step; write only while idle
// - one command at a time; req_ready is high while no command is in work
// - insert, search and delete run the low KEY_BITS (at most 16) key bits through
//   the bit-serial remainder unit, then probe from the home slot one slot after
//   another (1 to TABLE_SIZE slots, since the slot memory has a single read
//   port) and then load the output register
// - clear sweeps the slot memory one entry a cycle
// - the next command can be accepted in the cycle after a result is loaded;
//   no new command is taken before the last one has loaded its result
// - after reset the same sweep runs with req_ready low;
//   apb writes are taken during it
// - a stalled rsp holds its result in the output register; the next command
//   is accepted meanwhile and waits only at its own output load

module open_addressing_hash_table #(
	parameter int TABLE_SIZE = 32,
	parameter int KEY_BITS   = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  oaht_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output oaht_pkg::rsp_t  rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import oaht_pkg::*;

	localparam int SK   = (KEY_BITS < 16) ? KEY_BITS : 16;  // stored key width
	localparam int PW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW   = $clog2(TABLE_SIZE + 1);
	localparam int RW   = MOD_W + PW + 1;

	typedef struct packed {
		mark_t          mark;
		logic [SK-1:0]  key;
		logic [15:0]    score;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_PROBE,
		S_FIN
	} state_t;

	// reduce a value below 64 modulo the table size, six compare-subtract steps
	function automatic logic [PW-1:0] reduce_ts(input logic [MOD_W-1:0] v);
		logic [MOD_W-1:0] r;
		logic [RW-1:0]    lim;
		r = v;
		for (int i = MOD_W - 1; i >= 0; i--) begin
			lim = RW'(TABLE_SIZE) << i;
			if (RW'(r) >= lim) begin
				r = r - MOD_W'(lim);
			end
		end
		return PW'(r);
	endfunction

	// probe count is reported saturated to six bits
	function automatic logic [5:0] sat6(input logic [CW-1:0] p);
		logic [CW+5:0] pw;
		pw = (CW + 6)'(p);
		return (pw > (CW + 6)'(63)) ? 6'd63 : 6'(pw);
	endfunction

	// configuration registers
	logic [MOD_W-1:0] hash_mod_q;
	logic [4:0]       probe_step_q;

	// control and payload registers
	state_t           state_q;
	cmd_t             cmd_q;
	logic [SK-1:0]    key_q;
	logic [15:0]      score_q;
	logic [PW-1:0]    pos_q;
	logic [CW-1:0]    cnt_q;
	logic [PW-1:0]    clr_idx_q;
	logic             clr_cmd_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	// slot memory, one read and one write port, registered read data
	entry_t           slot_mem_q [TABLE_SIZE];
	entry_t           rd_data_q;
	logic [PW-1:0]    rd_addr;
	logic             wr_en;
	logic [PW-1:0]    wr_addr;
	entry_t           wr_data;

	// remainder unit
	logic             mod_start;
	logic             mod_done;
	logic [MOD_W-1:0] mod_div;
	logic [MOD_W-1:0] mod_rem;

	// probe datapath
	logic             req_fire;
	logic [PW-1:0]    home;
	logic [PW-1:0]    step_ts;
	logic [PW:0]      next_sum;
	logic [PW-1:0]    next_pos;
	logic             key_hit;
	logic             take;
	logic             hit;
	logic             miss;
	logic             last;
	logic             stop;
	rsp_t             res_n;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;

	// apb registers, decoded on the word address bit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mod_q   <= MOD_W'(7);
			probe_step_q <= 5'd9;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[2]))
				REG_MODULUS: hash_mod_q   <= pwdata[MOD_W-1:0];
				REG_STEP:    probe_step_q <= pwdata[4:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_MODULUS: prdata = {{(32 - MOD_W){1'b0}}, hash_mod_q};
			REG_STEP:    prdata = {27'd0, probe_step_q};
			default:     prdata = '0;
		endcase
	end

	// a zero modulus behaves as one
	assign mod_div   = (hash_mod_q == '0) ? MOD_W'(1) : hash_mod_q;
	assign mod_start = req_fire && (req.cmd != CMD_CLEAR);

	oaht_mod #(
		.DW (SK)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (req.key[SK-1:0]),
		.divisor  (mod_div),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// home slot and next probe position
	assign home     = reduce_ts(mod_rem);
	assign step_ts  = reduce_ts(MOD_W'(probe_step_q));
	assign next_sum = {1'b0, pos_q} + {1'b0, step_ts};
	assign next_pos = (next_sum >= (PW + 1)'(TABLE_SIZE)) ?
		PW'(next_sum - (PW + 1)'(TABLE_SIZE)) : PW'(next_sum);

	// decision on the slot read in the previous cycle
	always_comb begin
		key_hit = (rd_data_q.mark == MARK_USED) && (rd_data_q.key == key_q);
		take    = 1'b0;
		hit     = 1'b0;
		miss    = 1'b0;
		case (cmd_q)
			CMD_INSERT: take = (rd_data_q.mark != MARK_USED);
			CMD_SEARCH,
			CMD_DELETE: begin
				hit  = key_hit;
				miss = (rd_data_q.mark == MARK_EMPTY);
			end
			default: ;
		endcase
		last = (cnt_q == CW'(TABLE_SIZE - 1));
		stop = take || hit || miss || last;

		res_n             = '0;
		res_n.probe_count = sat6(cnt_q + 1'b1);
		if (take || hit) begin
			res_n.status = ST_OK;
			res_n.slot   = 5'(pos_q);
			if (hit && (cmd_q == CMD_SEARCH)) begin
				res_n.found_score = rd_data_q.score;
			end
		end else if (cmd_q == CMD_INSERT) begin
			res_n.status = ST_FULL;
		end else begin
			res_n.status = ST_MISS;
		end
	end

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '0;
		rd_addr = pos_q;
		case (state_q)
			S_CLR: begin
				// sweep writes an empty mark, key and score are don't care
				wr_en        = 1'b1;
				wr_addr      = clr_idx_q;
				wr_data.mark = MARK_EMPTY;
			end
			S_DIV: begin
				if (mod_done) begin
					rd_addr = home;
				end
			end
			S_PROBE: begin
				if (take) begin
					wr_en         = 1'b1;
					wr_data.mark  = MARK_USED;
					wr_data.key   = key_q;
					wr_data.score = score_q;
				end else if (hit && (cmd_q == CMD_DELETE)) begin
					wr_en        = 1'b1;
					wr_data      = rd_data_q;
					wr_data.mark = MARK_DELETED;
				end
				if (!stop) begin
					rd_addr = next_pos;
				end
			end
			default: ;
		endcase
	end

	// writes land only at the end of an operation or in the sweep, and the
	// next probe read follows the finish, idle and remainder states: no forwarding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= slot_mem_q[rd_addr];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_idx_q   <= '0;
			clr_cmd_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// output register: loaded from the finish state, freed by a transfer
			if ((state_q == S_FIN) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == PW'(TABLE_SIZE - 1)) begin
						// clear command reports all zero
						res_q   <= '0;
						state_q <= clr_cmd_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						cmd_q   <= req.cmd;
						key_q   <= req.key[SK-1:0];
						score_q <= req.score;
						if (req.cmd == CMD_CLEAR) begin
							clr_idx_q <= '0;
							clr_cmd_q <= 1'b1;
							state_q   <= S_CLR;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (mod_done) begin
						pos_q   <= home;
						cnt_q   <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (stop) begin
						res_q   <= res_n;
						state_q <= S_FIN;
					end else begin
						pos_q <= next_pos;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					// load once the previous result has been taken
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the remainder unit finishes only while the sequencer waits for it
	`ASSERT_NOW(a_mod_done_in_div, mod_done, state_q == S_DIV)
	// the slot memory is written only by the sweep or at the end of a probe run
	`ASSERT_NOW(a_wr_owner, wr_en, (state_q == S_CLR) || ((state_q == S_PROBE) && stop))
	// probe position stays inside the table
	`ASSERT_NOW(a_pos_range, state_q == S_PROBE, (PW + 1)'(pos_q) < (PW + 1)'(TABLE_SIZE))
	// a free output register is loaded in the cycle after the finish state
	`ASSERT_NEXT(a_fin_loads, (state_q == S_FIN) && !rsp_valid_q, rsp_valid_q)

endmodule

`default_nettype wire

[src/oaht_mod.sv]
// bit-serial remainder unit: dividend modulo a narrow divisor
`default_nettype none

module oaht_mod #(
	parameter int DW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DW-1:0]               dividend,
	input  logic [oaht_pkg::MOD_W-1:0]  divisor,
	output logic                        done,
	output logic [oaht_pkg::MOD_W-1:0]  rem
);
	import oaht_pkg::*;

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dv_q;
	logic [MOD_W-1:0] rem_q;
	logic [MOD_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [MOD_W:0]   trial;
	logic [MOD_W-1:0] rem_n;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dv_q[DW-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_n = MOD_W'(trial - {1'b0, div_q});
		end else begin
			rem_n = MOD_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			dv_q   <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(DW);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			rem_q  <= rem_n;
			dv_q   <= dv_q << 1;
			cnt_q  <= cnt_q - 1'b1;
			run_q  <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench of the open addressing hash table
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oaht_pkg::*;

	localparam int TABLE_SIZE = 32;
	localparam int KEY_BITS   = 16;

	// random part: phases of register settings, each with one of four idling modes
	localparam int PHASES          = 8;
	localparam int PHASE_CMDS      = 230;
	localparam int POOL_KEYS       = 16;
	// long receiver hold-off that backs the block up into its input
	localparam int RSP_HOLD_CYCLES = 300;
	// quiet cycles after the last result, longer than the slowest command
	localparam int TAIL_CYCLES     = 64;

	// one directed row: a register write or a command, the latter with an
	// optional expectation typed in by hand
	typedef struct packed {
		bit          is_reg;
		reg_idx_t    idx;
		logic [31:0] val;
		req_t        r;
		bit          typed;
		rsp_t        e;
	} script_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow copy of the slot store and of the two registers
	mark_t       shadow_mark [TABLE_SIZE];
	logic [15:0] shadow_key [TABLE_SIZE];
	logic [15:0] shadow_score [TABLE_SIZE];
	logic [5:0]  shadow_modulus = 6'd7;
	logic [4:0]  shadow_step    = 5'd9;

	// results owed by the block, oldest first
	rsp_t        table_results [$];
	script_row_t script [$];

	// pacing knobs, percent of cycles
	int unsigned send_idle_pct  = 0;
	int unsigned rsp_stall_pct  = 0;
	bit          hold_req       = 1'b0;

	// run statistics
	int unsigned mismatch_count = 0;
	int unsigned results_seen   = 0;
	int unsigned cmds_sent      = 0;
	int unsigned settings_used  = 0;
	int unsigned hits_seen      = 0;
	int unsigned misses_seen    = 0;
	int unsigned fulls_seen     = 0;
	int unsigned longest_stall  = 0;

	open_addressing_hash_table #(
		.TABLE_SIZE(TABLE_SIZE),
		.KEY_BITS  (KEY_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// apply one command to the shadow table and return the result it owes
	function automatic rsp_t table_op(req_t r);
		rsp_t        o;
		int unsigned m;
		int unsigned pos;
		int unsigned stride;
		int unsigned n;
		bit          done;
		o = '0;
		// a zero divisor behaves as one; a divisor above the table wraps again
		m = (shadow_modulus == 0) ? 1 : shadow_modulus;
		stride = shadow_step % TABLE_SIZE;
		pos = (r.key % m) % TABLE_SIZE;
		done = 1'b0;
		case (r.cmd)
			CMD_CLEAR: begin
				foreach (shadow_mark[i])
					shadow_mark[i] = MARK_EMPTY;
			end
			CMD_INSERT: begin
				// first free or tombstoned slot wins, duplicates are not checked
				o.status = ST_FULL;
				o.probe_count = 6'(TABLE_SIZE);
				for (n = 0; n < TABLE_SIZE && !done; n++) begin
					if (shadow_mark[pos] != MARK_USED) begin
						shadow_mark[pos] = MARK_USED;
						shadow_key[pos] = r.key;
						shadow_score[pos] = r.score;
						o.status = ST_OK;
						o.slot = 5'(pos);
						o.probe_count = 6'(n + 1);
						done = 1'b1;
					end else begin
						pos = (pos + stride) % TABLE_SIZE;
					end
				end
			end
			CMD_SEARCH, CMD_DELETE: begin
				// tombstones are passed over, an empty slot ends the probe
				o.status = ST_MISS;
				o.probe_count = 6'(TABLE_SIZE);
				for (n = 0; n < TABLE_SIZE && !done; n++) begin
					if (shadow_mark[pos] == MARK_USED && shadow_key[pos] == r.key) begin
						o.status = ST_OK;
						o.slot = 5'(pos);
						o.probe_count = 6'(n + 1);
						if (r.cmd == CMD_SEARCH)
							o.found_score = shadow_score[pos];
						else
							shadow_mark[pos] = MARK_DELETED;
						done = 1'b1;
					end else if (shadow_mark[pos] == MARK_EMPTY) begin
						o.probe_count = 6'(n + 1);
						done = 1'b1;
					end else begin
						pos = (pos + stride) % TABLE_SIZE;
					end
				end
			end
		endcase
		return o;
	endfunction

	function automatic void add_cmd(bit typed, cmd_t c, logic [15:0] k, logic [15:0] s,
			status_t st, logic [4:0] sl, logic [15:0] fs, logic [5:0] pc);
		script_row_t row;
		row = '0;
		row.r.cmd = c;
		row.r.key = k;
		row.r.score = s;
		row.typed = typed;
		row.e.status = st;
		row.e.slot = sl;
		row.e.found_score = fs;
		row.e.probe_count = pc;
		script.push_back(row);
	endfunction

	function automatic void add_reg(reg_idx_t idx, logic [31:0] val);
		script_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.idx = idx;
		row.val = val;
		script.push_back(row);
	endfunction

	// offer one command and wait for its transfer; called at a rising edge,
	// returns at the edge of the transfer with valid still high
	task automatic send_cmd(req_t r, bit typed, rsp_t typed_rsp);
		int unsigned gap;
		int unsigned waited;
		rsp_t        owed;
		gap = 0;
		if (send_idle_pct != 0) begin
			// now and then a long gap, so idle time lands on every stage of the work
			if ($urandom_range(99) < 10)
				gap = $urandom_range(60);
			else
				while ($urandom_range(99) < send_idle_pct)
					gap++;
		end
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (!req_ready);
		if (waited > longest_stall)
			longest_stall = waited;
		// transfer at this edge: the shadow moves in step with the block
		owed = table_op(r);
		table_results.push_back(typed ? typed_rsp : owed);
		cmds_sent++;
	endtask

	// drop valid and wait until every owed result has come back
	task automatic drain();
		req_valid <= 1'b0;
		while (table_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// write one register, then read it back; called at a rising edge,
	// returns after the port has gone idle
	task automatic apb_write_check(reg_idx_t idx, logic [31:0] val);
		logic [31:0] kept;
		kept = (idx == REG_MODULUS) ? {26'b0, val[5:0]} : {27'b0, val[4:0]};
		// setup then access
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_MODULUS)
			shadow_modulus = kept[5:0];
		else
			shadow_step = kept[4:0];
		// read back the same register
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== kept) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("register %s read back %h, wrote %h", idx.name(), prdata, kept);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// receiver pacing, with the long hold-off counted here
	initial begin : rsp_pacing
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// every result transfer is checked against the oldest owed result
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (table_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with nothing owed: %s %0d slot %0d score %h probes %0d",
						"status", rsp.status, rsp.slot, rsp.found_score,
						rsp.probe_count);
			end else begin
				want = table_results.pop_front();
				if (rsp.status !== want.status || rsp.slot !== want.slot ||
						rsp.found_score !== want.found_score ||
						rsp.probe_count !== want.probe_count) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result %0d: got status %0d slot %0d score %h probes %0d",
							results_seen, rsp.status, rsp.slot, rsp.found_score,
							rsp.probe_count);
						$display("  want status %0d slot %0d score %h probes %0d",
							want.status, want.slot, want.found_score,
							want.probe_count);
					end
				end
			end
			case (rsp.status)
				ST_OK:   hits_seen++;
				ST_MISS: misses_seen++;
				default: fulls_seen++;
			endcase
		end
	end

	initial begin : stimulus
		int unsigned phase_mod [PHASES];
		int unsigned phase_step [PHASES];
		logic [15:0] key_pool [POOL_KEYS];
		logic [15:0] anchor;
		int unsigned mod_eff;
		int unsigned roll;
		req_t        r;
		rsp_t        none;

		none = '0;
		foreach (shadow_mark[i]) begin
			shadow_mark[i] = MARK_EMPTY;
			shadow_key[i] = '0;
			shadow_score[i] = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, reset registers: modulus 7, step 9
		add_cmd(1, CMD_SEARCH, 16'h0000, 16'h0000, ST_MISS, 5'd0, 16'h0000, 6'd1);
		add_cmd(1, CMD_DELETE, 16'hFFFF, 16'hFFFF, ST_MISS, 5'd0, 16'h0000, 6'd1);
		add_cmd(1, CMD_INSERT, 16'h0000, 16'hFFFF, ST_OK,   5'd0, 16'h0000, 6'd1);
		add_cmd(1, CMD_INSERT, 16'hFFFF, 16'h0000, ST_OK,   5'd1, 16'h0000, 6'd1);
		add_cmd(1, CMD_SEARCH, 16'h0000, 16'h0000, ST_OK,   5'd0, 16'hFFFF, 6'd1);
		// collision at home slot 0, one step on
		add_cmd(1, CMD_INSERT, 16'd7,    16'h1234, ST_OK,   5'd9, 16'h0000, 6'd2);
		add_cmd(1, CMD_SEARCH, 16'd7,    16'h0000, ST_OK,   5'd9, 16'h1234, 6'd2);
		// tombstone at slot 0: skipped by search, reused by insert
		add_cmd(1, CMD_DELETE, 16'h0000, 16'h0000, ST_OK,   5'd0, 16'h0000, 6'd1);
		add_cmd(1, CMD_SEARCH, 16'd7,    16'h0000, ST_OK,   5'd9, 16'h1234, 6'd2);
		add_cmd(1, CMD_SEARCH, 16'd14,   16'h0000, ST_MISS, 5'd0, 16'h0000, 6'd3);
		add_cmd(1, CMD_INSERT, 16'd14,   16'hAAAA, ST_OK,   5'd0, 16'h0000, 6'd1);
		// duplicate key goes to the next free slot, search finds the first
		add_cmd(1, CMD_INSERT, 16'd14,   16'hBBBB, ST_OK,   5'd18, 16'h0000, 6'd3);
		add_cmd(1, CMD_SEARCH, 16'd14,   16'h5555, ST_OK,   5'd0, 16'hAAAA, 6'd1);
		add_cmd(1, CMD_CLEAR,  16'hFFFF, 16'hFFFF, ST_OK,   5'd0, 16'h0000, 6'd0);
		add_cmd(1, CMD_SEARCH, 16'd7,    16'h0000, ST_MISS, 5'd0, 16'h0000, 6'd1);
		// zero step: every probe stays home, so a second key finds the table full
		add_reg(REG_STEP, 32'd0);
		add_cmd(1, CMD_INSERT, 16'd3,    16'h0001, ST_OK,   5'd3, 16'h0000, 6'd1);
		add_cmd(1, CMD_INSERT, 16'd10,   16'h0002, ST_FULL, 5'd0, 16'h0000, 6'd32);
		add_cmd(1, CMD_SEARCH, 16'd10,   16'h0000, ST_MISS, 5'd0, 16'h0000, 6'd32);
		// zero divisor sends every key to slot 0
		add_reg(REG_MODULUS, 32'd0);
		add_cmd(1, CMD_INSERT, 16'hBEEF, 16'h5555, ST_OK,   5'd0, 16'h0000, 6'd1);
		// divisor above table size, widest step
		add_reg(REG_MODULUS, 32'd63);
		add_reg(REG_STEP, 32'd31);
		add_cmd(1, CMD_INSERT, 16'd62,   16'h7777, ST_OK,   5'd30, 16'h0000, 6'd1);
		add_cmd(1, CMD_INSERT, 16'd125,  16'h8888, ST_OK,   5'd29, 16'h0000, 6'd2);
		add_cmd(1, CMD_DELETE, 16'd125,  16'h0000, ST_OK,   5'd29, 16'h0000, 6'd2);
		add_cmd(0, CMD_SEARCH, 16'd125,  16'h0000, ST_OK,   5'd0, 16'h0000, 6'd0);
		add_cmd(0, CMD_SEARCH, 16'd62,   16'h0000, ST_OK,   5'd0, 16'h0000, 6'd0);
		add_cmd(0, CMD_INSERT, 16'h8000, 16'h8001, ST_OK,   5'd0, 16'h0000, 6'd0);

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				drain();
				apb_write_check(script[i].idx, script[i].val);
			end else begin
				send_cmd(script[i].r, script[i].typed, script[i].e);
			end
		end

		// random phases: extremes first, two random settings at the end
		phase_mod  = '{1, 32, 0, 63, 7, 16, 0, 0};
		phase_step = '{1, 31, 5, 16, 9, 0, 0, 0};
		phase_mod[6]  = $urandom_range(63);
		phase_mod[7]  = $urandom_range(63);
		phase_step[6] = $urandom_range(31);
		phase_step[7] = $urandom_range(31);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			apb_write_check(REG_MODULUS, phase_mod[p]);
			apb_write_check(REG_STEP, phase_step[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 66; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 66; end
				default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
			endcase
			// back-pressure: receiver holds off while commands keep coming
			if (p == 4) begin
				@(negedge clk);
				hold_req = 1'b1;
				@(posedge clk);
			end
			// half the pool shares one home slot, so probe chains get long
			mod_eff = (phase_mod[p] == 0) ? 1 : phase_mod[p];
			anchor = 16'($urandom);
			foreach (key_pool[j])
				key_pool[j] = (j < POOL_KEYS / 2) ? 16'($urandom) : 16'(anchor + j * mod_eff);
			for (int i = 0; i < PHASE_CMDS; i++) begin
				roll = $urandom_range(99);
				if (roll < 2)
					r.cmd = CMD_CLEAR;
				else if (roll < 45)
					r.cmd = CMD_INSERT;
				else if (roll < 75)
					r.cmd = CMD_SEARCH;
				else
					r.cmd = CMD_DELETE;
				if ($urandom_range(99) < 85)
					r.key = key_pool[$urandom_range(POOL_KEYS - 1)];
				else
					r.key = 16'($urandom);
				r.score = 16'($urandom);
				send_cmd(r, 1'b0, none);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d commands over %0d register writes, %0d results checked",
			cmds_sent, settings_used, results_seen);
		$display("outcomes: %0d done or found, %0d misses, %0d full; %s %0d cycles",
			hits_seen, misses_seen, fulls_seen, "longest input stall", longest_stall);
		if (mismatch_count == 0 && table_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results still owed", mismatch_count,
				table_results.size());
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog, several times the slowest correct run
	initial begin : watchdog
		#2000000;
		$display("timeout with %0d results owed", table_results.size());
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/oaht_pkg.sv
src/oaht_mod.sv
src/open_addressing_hash_table.sv
tb/sv/tb.sv
